// ----- sv/ptl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_pkg
// Shared widths, defaults and codes for the IPv4 prefix trie lookup block.
// ----------------------------------------------------------------------------
package ptl_pkg;

  // defaults for the top level parameters
  localparam int NODE_POOL_DEF = 4096;
  localparam int ADDR_BITS_DEF = 32;

  // beat field widths
  localparam int OP_W    = 2;
  localparam int IP_W    = 32;
  localparam int PLEN_W  = 6;
  localparam int VAL_W   = 16;
  localparam int NCNT_W  = 13;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic {
    ST_DONE = 1'b0,
    ST_FULL = 1'b1
  } status_t;

endpackage

// ----- sv/ptl_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_in_if
// Request channel: operation, address, prefix length and value.
// ----------------------------------------------------------------------------
interface ptl_in_if import ptl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [IP_W-1:0]         ip_address;
  logic [PLEN_W-1:0]       prefix_length;
  logic signed [VAL_W-1:0] entry_value;

  modport source (output valid, op, ip_address, prefix_length, entry_value, input ready);
  modport sink   (input valid, op, ip_address, prefix_length, entry_value, output ready);
endinterface

// ----- sv/ptl_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_out_if
// Result channel: lookup value, status and allocated node count.
// ----------------------------------------------------------------------------
interface ptl_out_if import ptl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] found_value;
  logic                    status;
  logic [NCNT_W-1:0]       node_count;

  modport source (output valid, found_value, status, node_count, input ready);
  modport sink   (input valid, found_value, status, node_count, output ready);
endinterface

// ----- sv/ptl_node_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptl_node_ram
// Node pool storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptl_node_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 40,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/ipv4_prefix_trie_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_prefix_trie_lookup
// Unibit binary trie for IPv4 longest-prefix match over a fixed node pool.
// ----------------------------------------------------------------------------
//   channel  dir  handshake         payload
//   in_ch    in   valid / ready     op, ip_address, prefix_length, entry_value
//   out_ch   out  valid / ready     found_value, status, node_count
//
// Ops: clear and the unused op code answer straight from S_IDLE. Add and
//   lookup walk the trie in S_STEP, one address bit per level; the loop is
//   at most one node RAM read or write per level.
// Reset: rst_n (sync, active low) empties the table to a bare root. The root
//   lives in flops, the pool RAM needs no clearing pass.
// Stalls: in_ch.ready is low during a walk and while the result register
//   holds a beat that out_ch has not taken.
// ----------------------------------------------------------------------------
module ipv4_prefix_trie_lookup import ptl_pkg::*; #(
  parameter int NODE_POOL = NODE_POOL_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ptl_in_if.sink    in_ch,
  ptl_out_if.source out_ch
);

  localparam int PTR_W = $clog2(NODE_POOL);
  localparam int CNT_W = $clog2(NODE_POOL + 1);
  localparam int LVL_W = $clog2(ADDR_BITS + 1);
  localparam int MEM_W = 2 * PTR_W + VAL_W;

  typedef enum logic { S_IDLE, S_STEP } state_t;
  // where the current node's contents come from
  typedef enum logic [1:0] { SRC_ROOT, SRC_MEM, SRC_FRESH } src_t;

  state_t                  state_r, state_nxt;
  src_t                    src_r, src_nxt;
  logic [OP_W-1:0]         op_r, op_nxt;
  logic [ADDR_BITS-1:0]    ip_r, ip_nxt;
  logic [LVL_W-1:0]        rem_r, rem_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic signed [VAL_W-1:0] best_r, best_nxt;
  logic [PTR_W-1:0]        cur_r, cur_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  // root node kept in flops
  logic [PTR_W-1:0]        root_l0_r, root_l0_nxt;
  logic [PTR_W-1:0]        root_l1_r, root_l1_nxt;
  logic signed [VAL_W-1:0] root_val_r, root_val_nxt;

  // result register
  logic                    ovalid_r, ovalid_nxt;
  logic signed [VAL_W-1:0] ofound_r, ofound_nxt;
  logic                    ostatus_r, ostatus_nxt;
  logic [NCNT_W-1:0]       ocount_r, ocount_nxt;

  // RAM ports
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic [MEM_W-1:0] rd_data_r;

  // current node view
  logic [PTR_W-1:0]        d_l0, d_l1, nxt_ptr;
  logic signed [VAL_W-1:0] d_val, best_upd;
  logic                    bit_b, can_fin, pool_full;
  logic [LVL_W-1:0]        plen_sat;

  ptl_node_ram #(
    .DEPTH (NODE_POOL),
    .DATA_W(MEM_W),
    .ADDR_W(PTR_W)
  ) u_ram (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data_r)
  );

  assign can_fin      = !ovalid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && can_fin;

  assign out_ch.valid       = ovalid_r;
  assign out_ch.found_value = ofound_r;
  assign out_ch.status      = ostatus_r;
  assign out_ch.node_count  = ocount_r;

  assign plen_sat = (int'(in_ch.prefix_length) > ADDR_BITS) ? LVL_W'(ADDR_BITS)
                                                             : LVL_W'(in_ch.prefix_length);
  assign pool_full = (cnt_r >= CNT_W'(NODE_POOL));

  always_comb begin
    case (src_r)
      SRC_ROOT: begin
        d_l0  = root_l0_r;
        d_l1  = root_l1_r;
        d_val = root_val_r;
      end
      SRC_MEM: begin
        d_l0  = rd_data_r[MEM_W-1 -: PTR_W];
        d_l1  = rd_data_r[VAL_W +: PTR_W];
        d_val = rd_data_r[VAL_W-1:0];
      end
      default: begin
        d_l0  = '0;
        d_l1  = '0;
        d_val = '0;
      end
    endcase
  end

  assign bit_b    = ip_r[ADDR_BITS-1];
  assign nxt_ptr  = bit_b ? d_l1 : d_l0;
  assign best_upd = (d_val != '0) ? d_val : best_r;

  always_comb begin
    state_nxt    = state_r;
    src_nxt      = src_r;
    op_nxt       = op_r;
    ip_nxt       = ip_r;
    rem_nxt      = rem_r;
    val_nxt      = val_r;
    best_nxt     = best_r;
    cur_nxt      = cur_r;
    cnt_nxt      = cnt_r;
    root_l0_nxt  = root_l0_r;
    root_l1_nxt  = root_l1_r;
    root_val_nxt = root_val_r;
    ovalid_nxt   = ovalid_r && !out_ch.ready;
    ofound_nxt   = ofound_r;
    ostatus_nxt  = ostatus_r;
    ocount_nxt   = ocount_r;
    wr_en        = 1'b0;
    wr_addr      = cur_r;
    wr_data      = {d_l0, d_l1, d_val};
    rd_en        = 1'b0;
    rd_addr      = nxt_ptr;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          case (in_ch.op)
            OP_ADD, OP_LOOKUP: begin
              state_nxt = S_STEP;
              src_nxt   = SRC_ROOT;
              op_nxt    = in_ch.op;
              ip_nxt    = in_ch.ip_address[ADDR_BITS-1:0];
              rem_nxt   = plen_sat;
              val_nxt   = in_ch.entry_value;
              best_nxt  = '0;
              cur_nxt   = '0;
            end
            OP_CLEAR: begin
              root_l0_nxt  = '0;
              root_l1_nxt  = '0;
              root_val_nxt = '0;
              cnt_nxt      = CNT_W'(1);
              ovalid_nxt   = 1'b1;
              ofound_nxt   = '0;
              ostatus_nxt  = ST_DONE;
              ocount_nxt   = NCNT_W'(1);
            end
            default: begin
              ovalid_nxt  = 1'b1;
              ofound_nxt  = '0;
              ostatus_nxt = ST_DONE;
              ocount_nxt  = NCNT_W'(cnt_r);
            end
          endcase
        end
      end

      S_STEP: begin
        if (rem_r == '0) begin
          // end of the prefix: store (add) or answer (lookup)
          if (can_fin) begin
            if (op_r == OP_ADD) begin
              if (src_r == SRC_ROOT) begin
                root_val_nxt = val_r;
              end else begin
                wr_en   = 1'b1;
                wr_data = {d_l0, d_l1, val_r};
              end
              ofound_nxt = '0;
            end else begin
              ofound_nxt = best_upd;
            end
            state_nxt   = S_IDLE;
            ovalid_nxt  = 1'b1;
            ostatus_nxt = ST_DONE;
            ocount_nxt  = NCNT_W'(cnt_r);
          end
        end else if (nxt_ptr != '0) begin
          // existing child: fetch it
          rd_en    = 1'b1;
          cur_nxt  = nxt_ptr;
          src_nxt  = SRC_MEM;
          rem_nxt  = rem_r - LVL_W'(1);
          ip_nxt   = ip_r << 1;
          best_nxt = best_upd;
        end else if (op_r != OP_ADD) begin
          // lookup fell off the trie
          if (can_fin) begin
            state_nxt   = S_IDLE;
            ovalid_nxt  = 1'b1;
            ofound_nxt  = best_upd;
            ostatus_nxt = ST_DONE;
            ocount_nxt  = NCNT_W'(cnt_r);
          end
        end else if (pool_full) begin
          // a freshly allocated node still has to land in the RAM as empty
          if (can_fin) begin
            if (src_r == SRC_FRESH) begin
              wr_en   = 1'b1;
              wr_data = '0;
            end
            state_nxt   = S_IDLE;
            ovalid_nxt  = 1'b1;
            ofound_nxt  = '0;
            ostatus_nxt = ST_FULL;
            ocount_nxt  = NCNT_W'(cnt_r);
          end
        end else begin
          // allocate a child at the top of the pool and link it in
          if (src_r == SRC_ROOT) begin
            if (bit_b) root_l1_nxt = cnt_r[PTR_W-1:0];
            else       root_l0_nxt = cnt_r[PTR_W-1:0];
          end else begin
            wr_en   = 1'b1;
            wr_data = bit_b ? {d_l0, cnt_r[PTR_W-1:0], d_val}
                            : {cnt_r[PTR_W-1:0], d_l1, d_val};
          end
          cur_nxt = cnt_r[PTR_W-1:0];
          src_nxt = SRC_FRESH;
          cnt_nxt = cnt_r + CNT_W'(1);
          rem_nxt = rem_r - LVL_W'(1);
          ip_nxt  = ip_r << 1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      src_r      <= SRC_ROOT;
      cnt_r      <= CNT_W'(1);
      root_l0_r  <= '0;
      root_l1_r  <= '0;
      root_val_r <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      src_r      <= src_nxt;
      cnt_r      <= cnt_nxt;
      root_l0_r  <= root_l0_nxt;
      root_l1_r  <= root_l1_nxt;
      root_val_r <= root_val_nxt;
      ovalid_r   <= ovalid_nxt;
    end
    op_r      <= op_nxt;
    ip_r      <= ip_nxt;
    rem_r     <= rem_nxt;
    val_r     <= val_nxt;
    best_r    <= best_nxt;
    cur_r     <= cur_nxt;
    ofound_r  <= ofound_nxt;
    ostatus_r <= ostatus_nxt;
    ocount_r  <= ocount_nxt;
  end

endmodule
